// File: sv/srrw_pkg.sv
`default_nettype none

package srrw_pkg;

   // default sizes of the stores
   localparam int WINDOW_SLOTS_DEF = 4096;
   localparam int MAX_SLICES_DEF   = 16384;
   localparam int SLICE_BYTES_DEF  = 1479;

   // fixed field widths
   localparam int SEQ_W       = 12;
   localparam int OFFSET_W    = 25;
   localparam int RELEASE_W   = 12;
   localparam int HALF_W      = 12;
   localparam int TOTAL_W     = 15;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 15;

   localparam logic [HALF_W-1:0]  HALF_RESET  = 12'd2048;
   localparam logic [TOTAL_W-1:0] TOTAL_RESET = 15'd0;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_WINDOW  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOTAL_SLICES = 4'd1;

   typedef enum logic [1:0] {
      MARK_EMPTY = 2'd0,
      MARK_QUEUE = 2'd1,
      MARK_USED  = 2'd2
   } mark_type;

   typedef struct packed {
      logic accept;       // latch request, start slot lookup and reciprocal multiply
      logic calc;         // quotient estimate and remainder
      logic set_oow;      // request falls outside the window
      logic write_slot;   // store slice index, mark slot received
      logic rel_check;    // release the slot at window start
      logic rel_mark;     // mark slice seen, queue far slot
      logic load_rsp;     // capture the response
      logic clr_restart;  // restart the clearing sweep
      logic clr_step;     // one entry of the clearing sweep
      logic clr_slots;    // sweep rewrites the slot marks
      logic clr_seen;     // sweep clears the slice bitmap
   } ctrl_cmd_type;

   typedef struct packed {
      mark_type lookup_mark;
      logic     seq_is_start;
      logic     walk_more;
      logic     clr_last;
      logic     wr_half;
      logic     wr_total;
   } dp_status_type;

endpackage

`default_nettype wire

// File: sv/srrw_ram.sv
`default_nettype none

module srrw_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first on a same-address collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/srrw_ctrl.sv
`default_nettype none

module srrw_ctrl import srrw_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          csr_valid,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd,
   output logic          busy,
   output logic          rsp_valid
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOKUP,
      S_INDEX,
      S_WALK_RD,
      S_WALK_CHK,
      S_WALK_MARK,
      S_DONE,
      S_CLEAR
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      clr_slots_ff, clr_slots_in;
   logic      clr_seen_ff, clr_seen_in;

   always_comb begin
      cmd           = '0;
      state_in      = state_ff;
      rsp_valid_in  = 1'b0;
      clr_slots_in  = clr_slots_ff;
      clr_seen_in   = clr_seen_ff;
      cmd.clr_slots = clr_slots_ff;
      cmd.clr_seen  = clr_seen_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start && !csr_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            cmd.calc = 1'b1;
            unique case (status.lookup_mark)
               MARK_USED:  state_in = S_IDLE;   // duplicate, no response
               MARK_QUEUE: state_in = S_INDEX;
               default: begin
                  cmd.set_oow = 1'b1;
                  state_in    = S_DONE;
               end
            endcase
         end
         S_INDEX: begin
            cmd.write_slot = 1'b1;
            state_in = status.seq_is_start ? S_WALK_RD : S_DONE;
         end
         S_WALK_RD: begin
            state_in = S_WALK_CHK;
         end
         S_WALK_CHK: begin
            if (status.walk_more) begin
               cmd.rel_check = 1'b1;
               state_in      = S_WALK_MARK;
            end else begin
               state_in = S_DONE;
            end
         end
         S_WALK_MARK: begin
            cmd.rel_mark = 1'b1;
            state_in     = S_WALK_CHK;
         end
         S_DONE: begin
            cmd.load_rsp = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               state_in     = S_IDLE;
               clr_slots_in = 1'b0;
               clr_seen_in  = 1'b0;
            end
         end
      endcase

      // a register write restarts the sweep; flags accumulate if one is running
      if (status.wr_half || status.wr_total) begin
         state_in        = S_CLEAR;
         cmd.clr_restart = 1'b1;
         clr_slots_in    = ((state_ff == S_CLEAR) && clr_slots_ff) || status.wr_half;
         clr_seen_in     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
         clr_slots_ff <= 1'b1;
         clr_seen_ff  <= 1'b1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_slots_ff <= clr_slots_in;
         clr_seen_ff  <= clr_seen_in;
      end
   end

   assign busy      = (state_ff != S_IDLE) || csr_valid;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: sv/srrw_datapath.sv
`default_nettype none

module srrw_datapath import srrw_pkg::*; #(
   parameter int WINDOW_SLOTS = WINDOW_SLOTS_DEF,
   parameter int MAX_SLICES   = MAX_SLICES_DEF,
   parameter int SLICE_BYTES  = SLICE_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [SEQ_W-1:0]       req_seq,
   input  logic [OFFSET_W-1:0]    req_packet_offset,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  ctrl_cmd_type           cmd,
   output dp_status_type          status,
   output logic [SEQ_W-1:0]       rsp_ack_seq,
   output logic [OFFSET_W-1:0]    rsp_ack_offset,
   output logic [SEQ_W-1:0]       rsp_ack_window_start,
   output logic                   rsp_out_of_window,
   output logic [SEQ_W-1:0]       rsp_release_first,
   output logic [RELEASE_W-1:0]   rsp_release_count,
   output logic                   rsp_slice_out_of_range,
   output logic                   rsp_transfer_done
);

   localparam int AW        = $clog2(WINDOW_SLOTS);      // slot address
   localparam int CW        = $clog2(WINDOW_SLOTS + 1);  // slot count up to ring
   localparam int QW        = CW + 1;
   localparam int SAW       = $clog2(MAX_SLICES);        // bitmap address
   localparam int SW        = $clog2(MAX_SLICES + 1);    // slice index incl. saturation
   localparam int CLR_DEPTH = (WINDOW_SLOTS > MAX_SLICES) ? WINDOW_SLOTS : MAX_SLICES;
   localparam int KW        = $clog2(CLR_DEPTH);
   localparam longint unsigned RECIP = (64'd1 << OFFSET_W) / SLICE_BYTES;
   localparam int RCW       = $clog2(RECIP + 1);
   localparam int PW        = OFFSET_W + RCW;
   localparam int DBW       = $clog2(SLICE_BYTES + 1);
   localparam int MW        = OFFSET_W + DBW;
   localparam int IW        = OFFSET_W + 1;

   // configuration
   logic [HALF_W-1:0]  half_ff, half_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               wr_half, wr_total;
   logic [CW-1:0]      h_eff, ring;
   logic [SW-1:0]      total_eff;

   // request and division
   logic [SEQ_W-1:0]    seq_ff;
   logic [OFFSET_W-1:0] off_ff;
   logic [AW-1:0]       first_ff;
   logic [PW-1:0]       prod_ff;
   logic [OFFSET_W-1:0] q_ff, rem_ff, q_est, rem_in;
   logic [MW-1:0]       qd;
   logic [IW-1:0]       q_c, idx_full;
   logic [OFFSET_W-1:0] r_c;
   logic [SW-1:0]       idx;
   logic [AW-1:0]       seq_addr;
   logic                seq_in_range;

   // window walk
   logic [AW-1:0]   ws_ff, ws_next;
   logic [CW-1:0]   ws_plus;
   logic [QW-1:0]   qsum, qwrap;
   logic [AW-1:0]   qslot;
   logic [CW-1:0]   released_ff;
   logic            oor_ff, oow_ff;
   logic            seen_mark_ff;
   logic [SAW-1:0]  seen_addr_ff;
   logic [SW-1:0]   count_ff;
   logic            slice_in;

   // clearing sweep
   logic [KW-1:0]   clr_ff;
   logic            clr_in_slots, clr_in_seen;

   // memories
   logic            mark_we;
   logic [AW-1:0]   mark_wa, mark_ra;
   mark_type        mark_wd;
   logic [1:0]      mark_rd;
   logic [SW-1:0]   slice_rd;
   logic            seen_we, seen_wd, seen_rd;
   logic [SAW-1:0]  seen_wa;

   // response
   logic [SEQ_W-1:0]     rsp_seq_ff, rsp_ws_ff, rsp_first_ff;
   logic [OFFSET_W-1:0]  rsp_off_ff;
   logic [RELEASE_W-1:0] rsp_count_ff;
   logic                 rsp_oow_ff, rsp_oor_ff, rsp_done_ff;

   // ---- configuration ----
   assign wr_half  = csr_valid && (csr_index == CSR_HALF_WINDOW);
   assign wr_total = csr_valid && (csr_index == CSR_TOTAL_SLICES);

   always_comb begin
      half_in  = half_ff;
      total_in = total_ff;
      if (wr_half) begin
         half_in = csr_data[HALF_W-1:0];
      end
      if (wr_total) begin
         total_in = csr_data[TOTAL_W-1:0];
      end
   end

   always_comb begin
      priority if (half_ff == '0) begin
         h_eff = CW'(1);
      end else if (32'(half_ff) > 32'(WINDOW_SLOTS / 2)) begin
         h_eff = CW'(WINDOW_SLOTS / 2);
      end else begin
         h_eff = CW'(half_ff);
      end
      if (32'(total_ff) > 32'(MAX_SLICES)) begin
         total_eff = SW'(MAX_SLICES);
      end else begin
         total_eff = SW'(total_ff);
      end
   end

   assign ring = h_eff << 1;

   // ---- slice index: ceil(offset / SLICE_BYTES) by reciprocal ----
   assign q_est  = OFFSET_W'(prod_ff >> OFFSET_W);
   assign qd     = MW'(q_est) * MW'(SLICE_BYTES);
   assign rem_in = OFFSET_W'(MW'(off_ff) - qd);

   always_comb begin
      if (rem_ff >= OFFSET_W'(SLICE_BYTES)) begin
         q_c = IW'(q_ff) + IW'(1);
         r_c = rem_ff - OFFSET_W'(SLICE_BYTES);
      end else begin
         q_c = IW'(q_ff);
         r_c = rem_ff;
      end
      idx_full = q_c + IW'(r_c != '0);
      if (32'(idx_full) > 32'(MAX_SLICES)) begin
         idx = SW'(MAX_SLICES);
      end else begin
         idx = SW'(idx_full);
      end
   end

   assign seq_addr     = AW'(seq_ff);
   assign seq_in_range = 32'(seq_ff) < 32'(ring);

   // ---- ring arithmetic ----
   assign ws_plus = CW'(ws_ff) + CW'(1);
   assign ws_next = (ws_plus == ring) ? '0 : AW'(ws_plus);
   assign qsum    = QW'(ws_ff) + QW'(h_eff) - QW'(1);
   assign qwrap   = (qsum >= QW'(ring)) ? (qsum - QW'(ring)) : qsum;
   assign qslot   = AW'(qwrap);

   assign slice_in = (32'(slice_rd) < 32'(total_eff)) && (32'(slice_rd) < 32'(MAX_SLICES));

   // ---- memory ports ----
   assign clr_in_slots = 32'(clr_ff) < 32'(WINDOW_SLOTS);
   assign clr_in_seen  = 32'(clr_ff) < 32'(MAX_SLICES);
   assign mark_ra      = cmd.accept ? AW'(req_seq) : ws_ff;

   always_comb begin
      mark_we = 1'b0;
      mark_wa = ws_ff;
      mark_wd = MARK_EMPTY;
      priority if (cmd.clr_step && cmd.clr_slots && clr_in_slots) begin
         mark_we = 1'b1;
         mark_wa = clr_ff[AW-1:0];
         mark_wd = (32'(clr_ff) < 32'(h_eff)) ? MARK_QUEUE : MARK_EMPTY;
      end else if (cmd.write_slot) begin
         mark_we = 1'b1;
         mark_wa = seq_addr;
         mark_wd = MARK_USED;
      end else if (cmd.rel_check) begin
         mark_we = 1'b1;
         mark_wa = ws_ff;
         mark_wd = MARK_EMPTY;
      end else if (cmd.rel_mark) begin
         mark_we = 1'b1;
         mark_wa = qslot;
         mark_wd = MARK_QUEUE;
      end else begin
         mark_we = 1'b0;
      end
   end

   always_comb begin
      seen_we = 1'b0;
      seen_wa = seen_addr_ff;
      seen_wd = 1'b1;
      priority if (cmd.clr_step && cmd.clr_seen && clr_in_seen) begin
         seen_we = 1'b1;
         seen_wa = clr_ff[SAW-1:0];
         seen_wd = 1'b0;
      end else if (cmd.rel_mark) begin
         seen_we = seen_mark_ff && !seen_rd;
      end else begin
         seen_we = 1'b0;
      end
   end

   srrw_ram #(.WIDTH(2), .DEPTH(WINDOW_SLOTS)) u_mark_ram (
      .clock   (clock),
      .wr_en   (mark_we),
      .wr_addr (mark_wa),
      .wr_data (mark_wd),
      .rd_addr (mark_ra),
      .rd_data (mark_rd)
   );

   srrw_ram #(.WIDTH(SW), .DEPTH(WINDOW_SLOTS)) u_slice_ram (
      .clock   (clock),
      .wr_en   (cmd.write_slot),
      .wr_addr (seq_addr),
      .wr_data (idx),
      .rd_addr (ws_ff),
      .rd_data (slice_rd)
   );

   srrw_ram #(.WIDTH(1), .DEPTH(MAX_SLICES)) u_seen_ram (
      .clock   (clock),
      .wr_en   (seen_we),
      .wr_addr (seen_wa),
      .wr_data (seen_wd),
      .rd_addr (slice_rd[SAW-1:0]),
      .rd_data (seen_rd)
   );

   // ---- control state ----
   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff     <= HALF_RESET;
         total_ff    <= TOTAL_RESET;
         ws_ff       <= '0;
         count_ff    <= '0;
         clr_ff      <= '0;
         released_ff <= '0;
         oor_ff      <= 1'b0;
         oow_ff      <= 1'b0;
      end else begin
         half_ff  <= half_in;
         total_ff <= total_in;

         if (wr_half) begin
            ws_ff <= '0;
         end else if (cmd.rel_check) begin
            ws_ff <= ws_next;
         end

         if (wr_half || wr_total) begin
            count_ff <= '0;
         end else if (seen_we && seen_wd) begin
            count_ff <= count_ff + SW'(1);
         end

         if (cmd.clr_restart) begin
            clr_ff <= '0;
         end else if (cmd.clr_step) begin
            clr_ff <= clr_ff + KW'(1);
         end

         if (cmd.accept) begin
            released_ff <= '0;
            oor_ff      <= 1'b0;
            oow_ff      <= 1'b0;
         end else begin
            if (cmd.set_oow) begin
               oow_ff <= 1'b1;
            end
            if (cmd.rel_check) begin
               released_ff <= released_ff + CW'(1);
               if (!slice_in) begin
                  oor_ff <= 1'b1;
               end
            end
         end
      end
   end

   // ---- payload ----
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         seq_ff   <= req_seq;
         off_ff   <= req_packet_offset;
         first_ff <= ws_ff;
         prod_ff  <= PW'(req_packet_offset) * PW'(RECIP);
      end
      if (cmd.calc) begin
         q_ff   <= q_est;
         rem_ff <= rem_in;
      end
      if (cmd.rel_check) begin
         seen_mark_ff <= slice_in;
         seen_addr_ff <= slice_rd[SAW-1:0];
      end
      if (cmd.load_rsp) begin
         rsp_seq_ff   <= seq_ff;
         rsp_off_ff   <= off_ff;
         rsp_ws_ff    <= SEQ_W'(ws_ff);
         rsp_oow_ff   <= oow_ff;
         rsp_first_ff <= SEQ_W'(first_ff);
         rsp_count_ff <= RELEASE_W'(released_ff);
         rsp_oor_ff   <= oor_ff;
         rsp_done_ff  <= 32'(count_ff) >= 32'(total_eff);
      end
   end

   assign status.lookup_mark  = seq_in_range ? mark_type'(mark_rd) : MARK_EMPTY;
   assign status.seq_is_start = (32'(seq_ff) == 32'(ws_ff));
   assign status.walk_more    = (released_ff < ring) && (mark_type'(mark_rd) == MARK_USED);
   assign status.clr_last     = (clr_ff == KW'(CLR_DEPTH - 1));
   assign status.wr_half      = wr_half;
   assign status.wr_total     = wr_total;

   assign rsp_ack_seq            = rsp_seq_ff;
   assign rsp_ack_offset         = rsp_off_ff;
   assign rsp_ack_window_start   = rsp_ws_ff;
   assign rsp_out_of_window      = rsp_oow_ff;
   assign rsp_release_first      = rsp_first_ff;
   assign rsp_release_count      = rsp_count_ff;
   assign rsp_slice_out_of_range = rsp_oor_ff;
   assign rsp_transfer_done      = rsp_done_ff;

endmodule

`default_nettype wire

// File: sv/selective_repeat_receive_window.sv
// Selective-repeat receive window.
// Request channel: start with req_seq / req_packet_offset; a request is taken
// on a rising edge with start high and busy low. busy stays high while a request
// is worked on, during the clearing sweep, and while csr_valid is high.
// Response channel: rsp_valid is high for exactly one cycle per response; the
// receiver cannot hold it off, so it must take every strobe. A duplicate of a
// received slot gives no response.
// Each request runs a slot lookup; a duplicate ends there, an out-of-window
// request goes to the response, and a queued slot is stored and, if it is at
// window start, runs the in-order release walk, which visits the slot marks
// one slot at a time, with a check and a mark step per released slot.
// The response strobe is registered from the done state that ends the work.
// CSR port: csr_index 0 = half window (restarts the transfer), 1 = total slices
// (clears the slice bitmap); csr_ready is always high, unknown indexes are dropped.
// Reset and a half-window write start a clearing sweep over the slot marks and
// the slice bitmap (a total-slices write sweeps the bitmap only), one entry per
// cycle, max(WINDOW_SLOTS, MAX_SLICES) entries. No request is taken until it ends.
`default_nettype none

module selective_repeat_receive_window import srrw_pkg::*; #(
   parameter int WINDOW_SLOTS = WINDOW_SLOTS_DEF,
   parameter int MAX_SLICES   = MAX_SLICES_DEF,
   parameter int SLICE_BYTES  = SLICE_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [SEQ_W-1:0]       req_seq,
   input  logic [OFFSET_W-1:0]    req_packet_offset,
   output logic                   rsp_valid,
   output logic [SEQ_W-1:0]       rsp_ack_seq,
   output logic [OFFSET_W-1:0]    rsp_ack_offset,
   output logic [SEQ_W-1:0]       rsp_ack_window_start,
   output logic                   rsp_out_of_window,
   output logic [SEQ_W-1:0]       rsp_release_first,
   output logic [RELEASE_W-1:0]   rsp_release_count,
   output logic                   rsp_slice_out_of_range,
   output logic                   rsp_transfer_done,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // writes are always taken; they must arrive only while idle or sweeping, which the block does not enforce
   assign csr_ready = 1'b1;

   srrw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .csr_valid (csr_valid),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   srrw_datapath #(
      .WINDOW_SLOTS (WINDOW_SLOTS),
      .MAX_SLICES   (MAX_SLICES),
      .SLICE_BYTES  (SLICE_BYTES)
   ) u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .req_seq                (req_seq),
      .req_packet_offset      (req_packet_offset),
      .csr_valid              (csr_valid),
      .csr_index              (csr_index),
      .csr_data               (csr_data),
      .cmd                    (cmd),
      .status                 (status),
      .rsp_ack_seq            (rsp_ack_seq),
      .rsp_ack_offset         (rsp_ack_offset),
      .rsp_ack_window_start   (rsp_ack_window_start),
      .rsp_out_of_window      (rsp_out_of_window),
      .rsp_release_first      (rsp_release_first),
      .rsp_release_count      (rsp_release_count),
      .rsp_slice_out_of_range (rsp_slice_out_of_range),
      .rsp_transfer_done      (rsp_transfer_done)
   );

endmodule

`default_nettype wire

// File: sv/srrw_checker.sv
`default_nettype none

module srrw_checker import srrw_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_valid,
   input logic                 rsp_out_of_window,
   input logic [SEQ_W-1:0]     rsp_ack_window_start,
   input logic [SEQ_W-1:0]     rsp_release_first,
   input logic [RELEASE_W-1:0] rsp_release_count,
   input logic                 rsp_slice_out_of_range
);

   // busy is still high in the cycle after a request is taken
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy low right after a request was taken");

   // one request gives at most one strobe, never on consecutive cycles
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_strobe_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response without a request in progress");

   // a dropped packet releases nothing
   a_oow_no_release: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_window) |->
         (rsp_release_count == '0) && !rsp_slice_out_of_range)
      else $error("out-of-window response reports a release");

   a_no_release_same_start: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_release_count == '0)) |->
         (rsp_ack_window_start == rsp_release_first))
      else $error("window start moved without a release");

endmodule

bind selective_repeat_receive_window srrw_checker u_srrw_checker (
   .clock                  (clock),
   .reset                  (reset),
   .start                  (start),
   .busy                   (busy),
   .rsp_valid              (rsp_valid),
   .rsp_out_of_window      (rsp_out_of_window),
   .rsp_ack_window_start   (rsp_ack_window_start),
   .rsp_release_first      (rsp_release_first),
   .rsp_release_count      (rsp_release_count),
   .rsp_slice_out_of_range (rsp_slice_out_of_range)
);

`default_nettype wire
